// ----- hdl/gregorian_date_query_top_assert.svh -----
`ifndef GREGORIAN_DATE_QUERY_TOP_ASSERT_SVH
`define GREGORIAN_DATE_QUERY_TOP_ASSERT_SVH

// Same-cycle check: when ante holds, cons must hold too
`define GDQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdq same-cycle check failed");

// Next-cycle check: when ante holds, cons must hold in the next cycle
`define GDQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdq next-cycle check failed");

`endif

// ----- hdl/gdq_pkg.sv -----
package gdq_pkg;

  // Input word: one Gregorian date
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } gdq_in_t;

  // Result word
  typedef struct packed {
    logic [2:0]  weekday;
    logic        is_week_end_day;
    logic        is_weekend;
    logic        is_business_day;
    logic [2:0]  days_to_week_end;
    logic [4:0]  days_to_month_end;
    logic [8:0]  days_to_year_end;
    logic [4:0]  next_day;
    logic [3:0]  next_month;
    logic [13:0] next_year;
    logic        leap;
    logic        date_invalid;
  } gdq_out_t;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } gdq_ld_t;

  localparam logic [6:0]  WEEKEND_MASK_RST = 7'd96;

  // floor(x / 100) = (x * 5243) >> 19 for x below 16784
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;
  // floor(x / 7) = (x * 37450) >> 18 for x below 32768
  localparam logic [15:0] DIV7_MUL     = 16'd37450;
  localparam int          DIV7_SHIFT   = 18;

  localparam logic [14:0] YEAR_SHIFT   = 15'd400;
  localparam logic [13:0] YEAR_MAX     = 14'd9999;
  localparam logic [3:0]  MONTH_JAN    = 4'd1;
  localparam logic [3:0]  MONTH_FEB    = 4'd2;
  localparam logic [3:0]  MONTH_DEC    = 4'd12;
  localparam logic [2:0]  WEEKDAY_SAT  = 3'd6;

  // Days in month for a common year, zero for a bad month code
  function automatic logic [4:0] month_len(input logic [3:0] mo);
    logic [4:0] len;
    unique case (mo)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of a common year before the first of the month
  function automatic logic [8:0] days_before(input logic [3:0] mo);
    logic [8:0] db;
    unique case (mo)
      4'd1:    db = 9'd0;
      4'd2:    db = 9'd31;
      4'd3:    db = 9'd59;
      4'd4:    db = 9'd90;
      4'd5:    db = 9'd120;
      4'd6:    db = 9'd151;
      4'd7:    db = 9'd181;
      4'd8:    db = 9'd212;
      4'd9:    db = 9'd243;
      4'd10:   db = 9'd273;
      4'd11:   db = 9'd304;
      4'd12:   db = 9'd334;
      default: db = 9'd0;
    endcase
    return db;
  endfunction

  // floor(31 * m / 12) with m the March-based month (January and February last)
  function automatic logic [4:0] month_offset(input logic [3:0] mo);
    logic [4:0] off;
    unique case (mo)
      4'd1:    off = 5'd28;
      4'd2:    off = 5'd31;
      4'd3:    off = 5'd2;
      4'd4:    off = 5'd5;
      4'd5:    off = 5'd7;
      4'd6:    off = 5'd10;
      4'd7:    off = 5'd12;
      4'd8:    off = 5'd15;
      4'd9:    off = 5'd18;
      4'd10:   off = 5'd20;
      4'd11:   off = 5'd23;
      4'd12:   off = 5'd25;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

endpackage

// ----- hdl/gdq_datapath.sv -----
module gdq_datapath (
  input  logic             clk,
  input  gdq_pkg::gdq_ld_t ld,
  input  gdq_pkg::gdq_in_t in_word,
  input  logic [6:0]       weekend_mask,
  output gdq_pkg::gdq_out_t out_word
);

  // Stage 1: shifted year and reciprocal products for /100
  gdq_pkg::gdq_in_t s1_in_r;
  logic [14:0]      s1_y_r;
  logic [27:0]      s1_py_r;
  logic [26:0]      s1_pyr_r;
  logic             s1_a;
  logic [14:0]      s1_y_nxt;

  always_comb begin
    s1_a     = (in_word.month <= gdq_pkg::MONTH_FEB);
    s1_y_nxt = {1'b0, in_word.year} + gdq_pkg::YEAR_SHIFT - {14'd0, s1_a};
  end

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      s1_in_r  <= in_word;
      s1_y_r   <= s1_y_nxt;
      s1_py_r  <= 28'(s1_y_nxt) * 28'(gdq_pkg::DIV100_MUL);
      s1_pyr_r <= 27'(in_word.year) * 27'(gdq_pkg::DIV100_MUL);
    end
  end

  // Stage 2: leap flag and weekday sum
  gdq_pkg::gdq_in_t s2_in_r;
  logic             s2_leap_r;
  logic [14:0]      s2_sum_r;
  logic [7:0]       s2_qy;
  logic [7:0]       s2_qyr;
  logic [13:0]      s2_rem100;
  logic             s2_leap_nxt;
  logic [14:0]      s2_sum_nxt;

  always_comb begin
    s2_qy       = s1_py_r[gdq_pkg::DIV100_SHIFT +: 8];
    s2_qyr      = s1_pyr_r[gdq_pkg::DIV100_SHIFT +: 8];
    s2_rem100   = s1_in_r.year - 14'({6'd0, s2_qyr} * 14'd100);
    s2_leap_nxt = ((s1_in_r.year[1:0] == 2'd0) && (s2_rem100 != 14'd0)) ||
                  ((s2_rem100 == 14'd0) && (s2_qyr[1:0] == 2'd0));
    s2_sum_nxt  = 15'(s1_in_r.day) + s1_y_r + (s1_y_r >> 2) - 15'(s2_qy)
                + 15'(s2_qy >> 2) + 15'(gdq_pkg::month_offset(s1_in_r.month));
  end

  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      s2_in_r   <= s1_in_r;
      s2_leap_r <= s2_leap_nxt;
      s2_sum_r  <= s2_sum_nxt;
    end
  end

  // Stage 3: range check, day counts, next date, product for mod 7
  logic        s3_leap_r;
  logic [14:0] s3_sum_r;
  logic [30:0] s3_p7_r;
  logic        s3_invalid_r;
  logic [4:0]  s3_dtm_r;
  logic [8:0]  s3_dty_r;
  logic [4:0]  s3_nd_r;
  logic [3:0]  s3_nm_r;
  logic [13:0] s3_ny_r;

  logic [4:0]  s3_dim;
  logic        s3_bad;
  logic [8:0]  s3_doy;
  logic [8:0]  s3_ydays;
  logic [4:0]  s3_nd;
  logic [3:0]  s3_nm;
  logic [13:0] s3_ny;

  always_comb begin
    s3_dim   = gdq_pkg::month_len(s2_in_r.month) +
               {4'd0, s2_leap_r && (s2_in_r.month == gdq_pkg::MONTH_FEB)};
    s3_bad   = (s2_in_r.month == 4'd0) || (s2_in_r.month > gdq_pkg::MONTH_DEC) ||
               (s2_in_r.day == 5'd0) || (s2_in_r.day > s3_dim);
    s3_doy   = gdq_pkg::days_before(s2_in_r.month) + 9'(s2_in_r.day) +
               {8'd0, s2_leap_r && (s2_in_r.month > gdq_pkg::MONTH_FEB)};
    s3_ydays = s2_leap_r ? 9'd366 : 9'd365;
    // roll day, then month, then year
    s3_nd = s2_in_r.day + 5'd1;
    s3_nm = s2_in_r.month;
    s3_ny = s2_in_r.year;
    if (s2_in_r.day == s3_dim) begin
      s3_nd = 5'd1;
      if (s2_in_r.month == gdq_pkg::MONTH_DEC) begin
        s3_nm = gdq_pkg::MONTH_JAN;
        s3_ny = (s2_in_r.year == gdq_pkg::YEAR_MAX) ? 14'd1 : s2_in_r.year + 14'd1;
      end else begin
        s3_nm = s2_in_r.month + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      s3_leap_r    <= s2_leap_r;
      s3_sum_r     <= s2_sum_r;
      s3_p7_r      <= 31'(s2_sum_r) * 31'(gdq_pkg::DIV7_MUL);
      s3_invalid_r <= s3_bad;
      s3_dtm_r     <= s3_dim - s2_in_r.day + 5'd1;
      s3_dty_r     <= s3_ydays - s3_doy + 9'd1;
      s3_nd_r      <= s3_nd;
      s3_nm_r      <= s3_nm;
      s3_ny_r      <= s3_ny;
    end
  end

  // Stage 4: weekday from the remainder, assemble the result word
  gdq_pkg::gdq_out_t s4_out_r;
  gdq_pkg::gdq_out_t s4_out_nxt;
  logic [11:0]       s4_q7;
  logic [14:0]       s4_rem7;
  logic [2:0]        s4_wd;

  always_comb begin
    s4_q7      = s3_p7_r[gdq_pkg::DIV7_SHIFT +: 12];
    s4_rem7    = s3_sum_r - 15'({3'd0, s4_q7} * 15'd7);
    s4_wd      = s4_rem7[2:0];
    s4_out_nxt = '0;
    if (s3_invalid_r) begin
      s4_out_nxt.date_invalid = 1'b1;
    end else begin
      s4_out_nxt.weekday           = s4_wd;
      s4_out_nxt.is_week_end_day   = (s4_wd == gdq_pkg::WEEKDAY_SAT);
      s4_out_nxt.is_weekend        = weekend_mask[s4_wd];
      s4_out_nxt.is_business_day   = ~weekend_mask[s4_wd];
      s4_out_nxt.days_to_week_end  = gdq_pkg::WEEKDAY_SAT - s4_wd;
      s4_out_nxt.days_to_month_end = s3_dtm_r;
      s4_out_nxt.days_to_year_end  = s3_dty_r;
      s4_out_nxt.next_day          = s3_nd_r;
      s4_out_nxt.next_month        = s3_nm_r;
      s4_out_nxt.next_year         = s3_ny_r;
      s4_out_nxt.leap              = s3_leap_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld4) begin
      s4_out_r <= s4_out_nxt;
    end
  end

  assign out_word = s4_out_r;

endmodule

// ----- hdl/gregorian_date_query_top.sv -----
// Throughput: one word per cycle while out_stall is low; four register stages,
// the last being the output register, each with its own valid bit, so bubbles
// close up under a stall.
// Reset: rst_n is synchronous, active low; it empties all stages and sets
// weekend_mask to Friday and Saturday. No clearing pass is needed.
module gregorian_date_query_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gdq_pkg::gdq_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gdq_pkg::gdq_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);

  logic [6:0]       mask_r;
  logic             v1_r, v2_r, v3_r, v4_r;
  logic             rdy1, rdy2, rdy3, rdy4;
  gdq_pkg::gdq_ld_t ld;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= gdq_pkg::WEEKEND_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      mask_r <= cfg_data;
    end
  end

  // A stage loads when it is empty or its word moves on
  always_comb begin
    rdy4   = !v4_r || !out_stall;
    rdy3   = !v3_r || rdy4;
    rdy2   = !v2_r || rdy3;
    rdy1   = !v1_r || rdy2;
    ld.ld1 = rdy1;
    ld.ld2 = rdy2;
    ld.ld3 = rdy3;
    ld.ld4 = rdy4;
  end

  assign in_stall = !rdy1;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  gdq_datapath u_datapath (
    .clk          (clk),
    .ld           (ld),
    .in_word      (in_data),
    .weekend_mask (mask_r),
    .out_word     (out_data)
  );

  assign out_valid = v4_r;

`include "gregorian_date_query_top_assert.svh"

  `GDQ_ASSERT_NOW(a_empty_front_takes, !v1_r, !in_stall)
  `GDQ_ASSERT_NEXT(a_no_drop_on_stall, v3_r && !rdy4, v3_r && v4_r)
  `GDQ_ASSERT_NOW(a_invalid_zeroed, out_valid && out_data.date_invalid, out_data.weekday == 3'd0 && out_data.next_year == 14'd0 && !out_data.leap && !out_data.is_weekend)
  `GDQ_ASSERT_NOW(a_week_fields, out_valid && !out_data.date_invalid, (out_data.weekday + out_data.days_to_week_end == 3'd6) && (out_data.is_business_day != out_data.is_weekend))

endmodule

// ----- dv/gregorian_date_query_top_tb.sv -----
module gregorian_date_query_top_tb;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  gdq_pkg::gdq_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  gdq_pkg::gdq_out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [6:0]        cfg_data = '0;

  // Expected result words, oldest first, and the mirrored weekend mask
  gdq_pkg::gdq_out_t answer_q[$];
  gdq_pkg::gdq_out_t want_word;
  logic [6:0]        mask_copy = gdq_pkg::WEEKEND_MASK_RST;
  int                error_count = 0;
  int                cycle_count = 0;
  bit                idle_on = 1'b1;

  gregorian_date_query_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- calendar

  function automatic bit is_leap(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Length of a month in the given year, zero for a bad month number
  function automatic int unsigned month_days(input int unsigned mo, input int unsigned yr);
    int unsigned len;
    case (mo)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = is_leap(yr) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  // Day of year of the first of the month, minus one, for a common year
  function automatic int unsigned days_ahead(input int unsigned mo);
    int unsigned sum;
    sum = 0;
    for (int k = 1; k < mo; k++) sum += month_days(k, 1);
    return sum;
  endfunction

  // Work out the whole result word for one date
  function automatic gdq_pkg::gdq_out_t calc_date_answer(input gdq_pkg::gdq_in_t w,
                                                         input logic [6:0] mask);
    gdq_pkg::gdq_out_t r;
    int unsigned       d, mo, yr, dim, wd, doy, ydays, shift, y, m;
    bit                lp;
    r     = '0;
    d     = 32'(w.day);
    mo    = 32'(w.month);
    yr    = 32'(w.year);
    lp    = is_leap(yr);
    dim   = month_days(mo, yr);
    if (dim == 0 || d == 0 || d > dim) begin
      r.date_invalid = 1'b1;
      return r;
    end
    // March-based month; shift the year by 400 to keep sums positive
    shift = (mo <= 32'(gdq_pkg::MONTH_FEB)) ? 1 : 0;
    y     = yr + 400 - shift;
    m     = mo + 12 * shift - 2;
    wd    = (d + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12) % 7;
    doy   = days_ahead(mo) + d + ((lp && mo > 32'(gdq_pkg::MONTH_FEB)) ? 1 : 0);
    ydays = lp ? 366 : 365;
    r.weekday           = 3'(wd);
    r.is_week_end_day   = (3'(wd) == gdq_pkg::WEEKDAY_SAT);
    r.is_weekend        = mask[wd];
    r.is_business_day   = !mask[wd];
    r.days_to_week_end  = 3'(6 - wd);
    r.days_to_month_end = 5'(dim - d + 1);
    r.days_to_year_end  = 9'(ydays - doy + 1);
    r.leap              = lp;
    // Roll over day, month and year
    if (d == dim) begin
      r.next_day = 5'd1;
      if (mo == 32'(gdq_pkg::MONTH_DEC)) begin
        r.next_month = gdq_pkg::MONTH_JAN;
        r.next_year  = (yr == 32'(gdq_pkg::YEAR_MAX)) ? 14'd1 : 14'(yr + 1);
      end else begin
        r.next_month = 4'(mo + 1);
        r.next_year  = 14'(yr);
      end
    end else begin
      r.next_day   = 5'(d + 1);
      r.next_month = 4'(mo);
      r.next_year  = 14'(yr);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (answer_q.size() == 0) begin
        report_mismatch("result word with nothing expected", 32'(out_data.weekday), 32'd0);
      end else begin
        want_word = answer_q.pop_front();
        check_field("weekday", 32'(out_data.weekday), 32'(want_word.weekday));
        check_field("is_week_end_day", 32'(out_data.is_week_end_day),
                    32'(want_word.is_week_end_day));
        check_field("is_weekend", 32'(out_data.is_weekend), 32'(want_word.is_weekend));
        check_field("is_business_day", 32'(out_data.is_business_day),
                    32'(want_word.is_business_day));
        check_field("days_to_week_end", 32'(out_data.days_to_week_end),
                    32'(want_word.days_to_week_end));
        check_field("days_to_month_end", 32'(out_data.days_to_month_end),
                    32'(want_word.days_to_month_end));
        check_field("days_to_year_end", 32'(out_data.days_to_year_end),
                    32'(want_word.days_to_year_end));
        check_field("next_day", 32'(out_data.next_day), 32'(want_word.next_day));
        check_field("next_month", 32'(out_data.next_month), 32'(want_word.next_month));
        check_field("next_year", 32'(out_data.next_year), 32'(want_word.next_year));
        check_field("leap", 32'(out_data.leap), 32'(want_word.leap));
        check_field("date_invalid", 32'(out_data.date_invalid),
                    32'(want_word.date_invalid));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stall the result side in random bursts
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 24)) @(negedge clk);
    end
  end

  // ---------------------------------------------------------------- driving

  // Offer one date word; called and returning at a falling edge
  task automatic send_date(input logic [4:0] d, input logic [3:0] mo, input logic [13:0] yr);
    gdq_pkg::gdq_in_t w;
    w.day   = d;
    w.month = mo;
    w.year  = yr;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    answer_q.push_back(calc_date_answer(w, mask_copy));
    @(negedge clk);
  endtask

  // Hold off new words until every expected result has come back
  task automatic wait_all_answers();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_weekend_mask(input logic [6:0] m);
    wait_all_answers();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    mask_copy = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed dates, biased to month ends and odd years; some noise
  task automatic send_random_date();
    logic [4:0]  d;
    logic [3:0]  mo;
    logic [13:0] yr;
    int unsigned dim;
    if ($urandom_range(0, 9) < 2) begin
      d  = 5'($urandom_range(0, 31));
      mo = 4'($urandom_range(0, 15));
      yr = 14'($urandom_range(0, 16383));
    end else begin
      mo = 4'($urandom_range(1, 12));
      case ($urandom_range(0, 3))
        0:       yr = 14'($urandom_range(0, 16383));
        1:       yr = 14'($urandom_range(1, 9999));
        2:       yr = 14'($urandom_range(9996, 10003));
        default: yr = 14'(100 * $urandom_range(0, 163));
      endcase
      dim = month_days(mo, yr);
      d   = ($urandom_range(0, 3) == 0) ? 5'(dim) : 5'($urandom_range(1, dim));
    end
    send_date(d, mo, yr);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_calendar_rules();
    send_date(5'd1,  4'd1,  14'd2024);
    send_date(5'd29, 4'd2,  14'd2024);
    send_date(5'd28, 4'd2,  14'd2023);
    send_date(5'd28, 4'd2,  14'd1900);
    send_date(5'd29, 4'd2,  14'd2000);
    send_date(5'd31, 4'd12, 14'd9999);
    send_date(5'd31, 4'd12, 14'd16383);
    send_date(5'd1,  4'd1,  14'd0);
    send_date(5'd1,  4'd1,  14'd1);
    send_date(5'd31, 4'd12, 14'd2024);
    send_date(5'd30, 4'd4,  14'd2024);
    send_date(5'd1,  4'd1,  14'd1970);
    send_date(5'd31, 4'd5,  14'd2024);
    send_date(5'd1,  4'd6,  14'd2024);
    send_date(5'd2,  4'd6,  14'd2024);
  endtask

  task automatic test_invalid_dates();
    send_date(5'd29, 4'd2,  14'd2023);
    send_date(5'd29, 4'd2,  14'd1900);
    send_date(5'd31, 4'd4,  14'd2024);
    send_date(5'd0,  4'd5,  14'd2024);
    send_date(5'd15, 4'd0,  14'd2024);
    send_date(5'd1,  4'd13, 14'd2024);
    send_date(5'd31, 4'd15, 14'd16383);
    send_date(5'd0,  4'd0,  14'd0);
  endtask

  // One whole week under each extreme mask
  task automatic test_mask_settings();
    load_weekend_mask(7'h7F);
    for (int k = 2; k <= 8; k++) send_date(5'(k), 4'd6, 14'd2024);
    load_weekend_mask(7'h00);
    for (int k = 2; k <= 8; k++) send_date(5'(k), 4'd6, 14'd2024);
  endtask

  task automatic test_random_dates();
    for (int k = 0; k < 5; k++) begin
      load_weekend_mask(k == 0 ? 7'h2A : k == 4 ? gdq_pkg::WEEKEND_MASK_RST :
                        7'($urandom_range(0, 127)));
      repeat (80) send_random_date();
    end
  endtask

  // Back-to-back words with no idling on either side
  task automatic test_steady_tail();
    idle_on = 1'b0;
    repeat (50) send_random_date();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_calendar_rules();
    test_invalid_dates();
    test_mask_settings();
    test_random_dates();
    test_steady_tail();
    wait_all_answers();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
